>>> rtl/monome_dinome_stream_decoder_macros.svh
// Assertion macros used by the monome-dinome stream decoder RTL.
`ifndef MONOME_DINOME_STREAM_DECODER_MACROS_SVH
`define MONOME_DINOME_STREAM_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// Plain property check, disabled while reset is high.
`define MDSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication check, disabled while reset is high.
`define MDSD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check, disabled while reset is high.
`define MDSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MDSD_ASSERT(lbl, clk, rst, prop, msg)
`define MDSD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define MDSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/mdsd_pkg.sv
// Types, constants and the letter map lookup of the monome-dinome stream decoder.
`default_nettype none

package mdsd_pkg;

   localparam int DIGIT_W            = 4;
   localparam int LETTER_W           = 5;
   localparam int CODE_W             = 5;
   localparam int TOTAL_W            = 16;
   localparam int MAP_W              = 60;
   localparam int CSR_INDEX_W        = 3;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam logic [CODE_W-1:0]  ROW_LOW_BASE  = CODE_W'(8);
   localparam logic [CODE_W-1:0]  ROW_HIGH_BASE = CODE_W'(16);
   localparam logic [CODE_W-1:0]  MAP_CODES     = CODE_W'(24);
   localparam logic [DIGIT_W-1:0] DIGIT_LIMIT   = DIGIT_W'(10);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INDICATOR_LOW   = 3'd0,
      CSR_INDICATOR_HIGH  = 3'd1,
      CSR_LETTER_MAP_LOW  = 3'd2,
      CSR_LETTER_MAP_HIGH = 3'd3,
      CSR_FILLER_LETTER   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIGIT_W-1:0]  indicator_low;
      logic [DIGIT_W-1:0]  indicator_high;
      logic [MAP_W-1:0]    letter_map_low;
      logic [MAP_W-1:0]    letter_map_high;
      logic [LETTER_W-1:0] filler_letter;
   } cfg_type;

   // Carried dinome state: an indicator has been seen and waits for its partner.
   typedef struct packed {
      logic pending;
      logic row_high;
   } dinome_type;

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                has_letter;
      logic                invalid_token;
      logic [TOTAL_W-1:0]  token_total;
      logic [TOTAL_W-1:0]  valid_total;
      logic                end_of_run;
   } rsp_type;

   // Codes 0 to 11 sit in the low map word, 12 to 23 in the high word.
   // Anything beyond the map returns the filler letter.
   function automatic logic [LETTER_W-1:0] map_letter(
      input logic [MAP_W-1:0]    map_low,
      input logic [MAP_W-1:0]    map_high,
      input logic [CODE_W-1:0]   code,
      input logic [LETTER_W-1:0] filler
   );
      logic [2*MAP_W-1:0] map_all;
      logic [6:0]         pos;
      map_all = {map_high, map_low};
      pos     = 7'({code, 2'b00}) + 7'(code);
      if (code < MAP_CODES) begin
         map_letter = map_all[pos +: LETTER_W];
      end else begin
         map_letter = filler;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/monome_dinome_stream_decoder.sv
// Top level of the monome-dinome stream decoder: registers, handshakes and config.
// A word accepted into the input stage moves on into the result register, which drives rsp_.
// Throughput: one digit word per cycle unless a result is stalled; the input stage and result register form the pipe.
// A digit that makes no result leaves the input stage even while the result is stalled.
// Reset (synchronous, active high) empties both stages, clears the counters and the
// pending indicator, and loads indicators 0 and 1, zero letter maps and a zero filler.
`default_nettype none

`include "monome_dinome_stream_decoder_macros.svh"

module monome_dinome_stream_decoder #(
   parameter int COUNT_BITS = mdsd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Digit stream.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [mdsd_pkg::DIGIT_W-1:0]         req_digit,
   input  logic                                 req_last,
   // Decoded tokens.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mdsd_pkg::LETTER_W-1:0]        rsp_letter,
   output logic                                 rsp_has_letter,
   output logic                                 rsp_invalid_token,
   output logic [mdsd_pkg::TOTAL_W-1:0]         rsp_token_total,
   output logic [mdsd_pkg::TOTAL_W-1:0]         rsp_valid_total,
   output logic                                 rsp_end_of_run,
   // Register writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mdsd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mdsd_pkg::MAP_W-1:0]           csr_data
);
   import mdsd_pkg::*;

   // Configuration registers.
   cfg_type               cfg_ff;
   cfg_type               cfg_in;

   // Input stage: the accepted digit word waits here until it advances.
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [DIGIT_W-1:0]    s1_digit_ff;
   logic                  s1_last_ff;

   // Stream state carried from word to word.
   dinome_type            dinome_ff;
   dinome_type            dinome_in;
   logic [COUNT_BITS-1:0] token_cnt_ff;
   logic [COUNT_BITS-1:0] token_cnt_in;
   logic [COUNT_BITS-1:0] valid_cnt_ff;
   logic [COUNT_BITS-1:0] valid_cnt_in;

   // Result register.
   logic                  out_valid_ff;
   logic                  out_valid_in;
   rsp_type               out_rsp_ff;

   // Decode results for the word in the input stage.
   logic                  emit;
   rsp_type               step_rsp;
   logic                  advance;
   logic                  req_fire;

   mdsd_token_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .cfg            (cfg_ff),
      .digit          (s1_digit_ff),
      .last           (s1_last_ff),
      .dinome         (dinome_ff),
      .token_cnt      (token_cnt_ff),
      .valid_cnt      (valid_cnt_ff),
      .emit           (emit),
      .rsp            (step_rsp),
      .dinome_next    (dinome_in),
      .token_cnt_next (token_cnt_in),
      .valid_cnt_next (valid_cnt_in)
   );

   // The input stage moves on when its word makes no result, or when the result
   // register is empty or being emptied this cycle.
   assign advance   = s1_valid_ff && (!emit || !out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);
   assign out_valid_in = (advance && emit) || (out_valid_ff && !rsp_ready);

   // Register writes are always taken; the user must send them only while the stream is idle; not enforced.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_INDICATOR_LOW:   cfg_in.indicator_low   = csr_data[DIGIT_W-1:0];
            CSR_INDICATOR_HIGH:  cfg_in.indicator_high  = csr_data[DIGIT_W-1:0];
            CSR_LETTER_MAP_LOW:  cfg_in.letter_map_low  = csr_data;
            CSR_LETTER_MAP_HIGH: cfg_in.letter_map_high = csr_data;
            CSR_FILLER_LETTER:   cfg_in.filler_letter   = csr_data[LETTER_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.indicator_low   <= DIGIT_W'(0);
         cfg_ff.indicator_high  <= DIGIT_W'(1);
         cfg_ff.letter_map_low  <= '0;
         cfg_ff.letter_map_high <= '0;
         cfg_ff.filler_letter   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         dinome_ff    <= '0;
         token_cnt_ff <= '0;
         valid_cnt_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            dinome_ff    <= dinome_in;
            token_cnt_ff <= token_cnt_in;
            valid_cnt_ff <= valid_cnt_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_digit_ff <= req_digit;
         s1_last_ff  <= req_last;
      end
      if (advance && emit) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_letter        = out_rsp_ff.letter;
   assign rsp_has_letter    = out_rsp_ff.has_letter;
   assign rsp_invalid_token = out_rsp_ff.invalid_token;
   assign rsp_token_total   = out_rsp_ff.token_total;
   assign rsp_valid_total   = out_rsp_ff.valid_total;
   assign rsp_end_of_run    = out_rsp_ff.end_of_run;

   // A word without a token is only ever the end-of-run marker, and it is blank.
   `MDSD_ASSERT_IMPL(a_marker_blank, clock, reset, out_valid_ff && !out_rsp_ff.has_letter, out_rsp_ff.end_of_run && (out_rsp_ff.letter == '0) && !out_rsp_ff.invalid_token, "token-less result is not a blank end-of-run marker")

   // An invalid flag always comes with a token.
   `MDSD_ASSERT_IMPL(a_invalid_has_token, clock, reset, out_valid_ff && out_rsp_ff.invalid_token, out_rsp_ff.has_letter, "invalid token flagged without a token")

   // Valid tokens are a subset of all tokens.
   `MDSD_ASSERT_IMPL(a_totals_order, clock, reset, out_valid_ff, out_rsp_ff.valid_total <= out_rsp_ff.token_total, "valid total exceeds token total")

   // The last digit of a run leaves the stream state cleared.
   `MDSD_ASSERT_NEXT(a_run_clears, clock, reset, advance && s1_last_ff, (token_cnt_ff == '0) && (valid_cnt_ff == '0) && !dinome_ff.pending, "stream state not cleared after the last digit")

endmodule

`default_nettype wire

>>> rtl/mdsd_token_step.sv
// Combinational token decode and counter update for one digit.
`default_nettype none

module mdsd_token_step #(
   parameter int COUNT_BITS = mdsd_pkg::COUNT_BITS_DEFAULT
) (
   input  mdsd_pkg::cfg_type                     cfg,
   input  logic [mdsd_pkg::DIGIT_W-1:0]          digit,
   input  logic                                  last,
   input  mdsd_pkg::dinome_type                  dinome,
   input  logic [COUNT_BITS-1:0]                 token_cnt,
   input  logic [COUNT_BITS-1:0]                 valid_cnt,
   output logic                                  emit,
   output mdsd_pkg::rsp_type                     rsp,
   output mdsd_pkg::dinome_type                  dinome_next,
   output logic [COUNT_BITS-1:0]                 token_cnt_next,
   output logic [COUNT_BITS-1:0]                 valid_cnt_next
);
   import mdsd_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic                  is_digit;
   logic                  is_ind;
   logic                  lt_low;
   logic                  lt_high;
   logic [DIGIT_W-1:0]    rank;
   logic [CODE_W-1:0]     code;
   logic                  token;
   logic                  invalid;
   logic [LETTER_W-1:0]   letter;
   dinome_type            dinome_after;
   logic [COUNT_BITS-1:0] token_after;
   logic [COUNT_BITS-1:0] valid_after;
   logic [TOTAL_W-1:0]    token_sat;
   logic [TOTAL_W-1:0]    valid_sat;

   assign is_digit = digit < DIGIT_LIMIT;
   assign is_ind   = (digit == cfg.indicator_low) || (digit == cfg.indicator_high);

   // The rank of a digit is the digit less the indicators below it; equal
   // indicators count once.
   assign lt_low  = cfg.indicator_low < digit;
   assign lt_high = (cfg.indicator_high < digit) && (cfg.indicator_high != cfg.indicator_low);
   assign rank    = digit - DIGIT_W'(lt_low) - DIGIT_W'(lt_high);

   always_comb begin
      token        = 1'b0;
      invalid      = 1'b0;
      code         = CODE_W'(rank);
      dinome_after = dinome;
      if (dinome.pending) begin
         token               = 1'b1;
         dinome_after.pending = 1'b0;
         invalid             = !is_digit || is_ind;
         code = (dinome.row_high ? ROW_HIGH_BASE : ROW_LOW_BASE) + CODE_W'(rank);
      end else if (is_digit) begin
         if (is_ind) begin
            if (last) begin
               token   = 1'b1;
               invalid = 1'b1;
            end else begin
               dinome_after.pending  = 1'b1;
               dinome_after.row_high = digit != cfg.indicator_low;
            end
         end else begin
            token = 1'b1;
         end
      end
   end

   always_comb begin
      if (invalid) begin
         letter = cfg.filler_letter;
      end else begin
         letter = map_letter(cfg.letter_map_low, cfg.letter_map_high, code, cfg.filler_letter);
      end
   end

   assign token_after = token_cnt + COUNT_BITS'(token && (token_cnt != COUNT_MAX));
   assign valid_after = valid_cnt + COUNT_BITS'(token && !invalid && (valid_cnt != COUNT_MAX));

   generate
      if (COUNT_BITS > TOTAL_W) begin : g_sat
         assign token_sat = (|token_after[COUNT_BITS-1:TOTAL_W]) ? {TOTAL_W{1'b1}}
                                                                 : token_after[TOTAL_W-1:0];
         assign valid_sat = (|valid_after[COUNT_BITS-1:TOTAL_W]) ? {TOTAL_W{1'b1}}
                                                                 : valid_after[TOTAL_W-1:0];
      end else begin : g_ext
         assign token_sat = TOTAL_W'(token_after);
         assign valid_sat = TOTAL_W'(valid_after);
      end
   endgenerate

   assign emit = token || last;

   always_comb begin
      rsp.letter        = token ? letter : '0;
      rsp.has_letter    = token;
      rsp.invalid_token = invalid;
      rsp.token_total   = token_sat;
      rsp.valid_total   = valid_sat;
      rsp.end_of_run    = last;
   end

   // The end of a run clears the counters and any pending indicator.
   assign dinome_next    = last ? '0 : dinome_after;
   assign token_cnt_next = last ? '0 : token_after;
   assign valid_cnt_next = last ? '0 : valid_after;

endmodule

`default_nettype wire
